// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the filter RTL.
// Stand-alone header; the including module supplies clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");

// Check that a trigger at one edge implies a consequence at the next edge.
`define ASSERT_NEXT(lbl, trig, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/iirdf1_pkg.sv =====
// Constants and types for the direct form I IIR filter.
// No dependencies.
package iirdf1_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int FRAC_BITS  = 14;
   localparam int NUM_FWD    = 3;
   localparam int NUM_BACK   = 3;
   localparam int TAP_CNT_W  = 2;
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   // six products plus rounding term get four more bits of headroom
   localparam int ACC_W      = PROD_W + 4;
   localparam int SHIFT_W    = ACC_W - FRAC_BITS;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [ACC_W-1:0]    acc_type;
   typedef logic signed [SHIFT_W-1:0]  shift_type;

   localparam acc_type   ROUND_HALF = acc_type'(1) <<< (FRAC_BITS - 1);
   localparam shift_type SAT_HI     = shift_type'(32767);
   localparam shift_type SAT_LO     = shift_type'(-32768);
   localparam sample_type OUT_HI    = 16'sh7fff;
   localparam sample_type OUT_LO    = 16'sh8000;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_FORWARD_TAPS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FEEDBACK_TAPS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FWD_COEF_0    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FWD_COEF_1    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FWD_COEF_2    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BACK_COEF_0   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BACK_COEF_1   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_BACK_COEF_2   = 3'd7;

   localparam coef_type FWD_COEF_0_RESET = 16'sd16384;

endpackage

// ===== hdl/iir_direct_form_one_filter.sv =====
// Direct form I IIR filter, Q2.14 coefficients, rounded and saturated output.
// Depends on iirdf1_pkg and assert_macros.svh.
//
//   channel   ports   payload
//   request   req_*   tdata[15:0] sample
//   response  rsp_*   tdata[15:0] filtered, tuser[0] clipped
//   config    csr_*   index 0..7, wdata[15:0]
//
// One sample per cycle sustained while rsp_tready holds; a request goes to the response
// through the input register, then six multiplies, sum, round and saturate into the
// output register. The y[n-1] feedback closes through that one stage.
// Reset is synchronous: histories clear to zero, registers to their defaults.
// A stalled response holds the output register; the input register still
// takes one more request behind it.
`include "assert_macros.svh"

module iir_direct_form_one_filter
   import iirdf1_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,    // [15:0] sample
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SAMPLE_W-1:0]   rsp_tdata,    // [15:0] filtered
   output logic                  rsp_tuser,    // [0] clipped
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [TAP_CNT_W-1:0] fwd_taps_ff;
   logic [TAP_CNT_W-1:0] back_taps_ff;
   coef_type             fwd_coef_ff  [NUM_FWD];
   coef_type             back_coef_ff [NUM_BACK];

   sample_type past_in_ff  [NUM_FWD-1];
   sample_type past_out_ff [NUM_BACK];

   logic       in_valid_ff, in_valid_in;
   sample_type in_sample_ff;
   logic       out_valid_ff, out_valid_in;
   sample_type out_filtered_ff;
   logic       out_clipped_ff;

   logic       advance;
   logic       fire;
   logic       req_fire;
   acc_type    acc;
   acc_type    acc_rnd;
   shift_type  shifted;
   sample_type result;
   logic       clip;

   // handshake: advance when the output register is free or being drained
   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_filtered_ff;
   assign rsp_tuser  = out_clipped_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // six gated products summed at full precision
   always_comb begin
      sample_type xv;
      prod_type   p;
      acc = '0;
      for (int k = 0; k < NUM_FWD; k++) begin
         xv = (k == 0) ? in_sample_ff : past_in_ff[(k == 0) ? 0 : k - 1];
         p  = fwd_coef_ff[k] * xv;
         if (TAP_CNT_W'(k) < fwd_taps_ff) begin
            acc = acc + acc_type'(p);
         end
      end
      for (int k = 0; k < NUM_BACK; k++) begin
         p = back_coef_ff[k] * past_out_ff[k];
         if (TAP_CNT_W'(k) < back_taps_ff) begin
            acc = acc + acc_type'(p);
         end
      end
   end

   // round half up, floor shift, saturate
   always_comb begin
      acc_rnd = acc + ROUND_HALF;
      shifted = acc_rnd[ACC_W-1:FRAC_BITS];
      result  = shifted[SAMPLE_W-1:0];
      clip    = 1'b0;
      if (shifted > SAT_HI) begin
         result = OUT_HI;
         clip   = 1'b1;
      end else if (shifted < SAT_LO) begin
         result = OUT_LO;
         clip   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_sample_ff <= req_tdata;
      end
      if (fire) begin
         out_filtered_ff <= result;
         out_clipped_ff  <= clip;
      end
   end

   // histories shift on every computed sample, whatever the tap counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_FWD - 1; k++) begin
            past_in_ff[k] <= '0;
         end
         for (int k = 0; k < NUM_BACK; k++) begin
            past_out_ff[k] <= '0;
         end
      end else if (fire) begin
         past_in_ff[0] <= in_sample_ff;
         for (int k = 1; k < NUM_FWD - 1; k++) begin
            past_in_ff[k] <= past_in_ff[k-1];
         end
         past_out_ff[0] <= result;
         for (int k = 1; k < NUM_BACK; k++) begin
            past_out_ff[k] <= past_out_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_taps_ff     <= TAP_CNT_W'(1);
         back_taps_ff    <= '0;
         fwd_coef_ff[0]  <= FWD_COEF_0_RESET;
         fwd_coef_ff[1]  <= '0;
         fwd_coef_ff[2]  <= '0;
         back_coef_ff[0] <= '0;
         back_coef_ff[1] <= '0;
         back_coef_ff[2] <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_FORWARD_TAPS:  fwd_taps_ff     <= csr_wdata[TAP_CNT_W-1:0];
            REG_FEEDBACK_TAPS: back_taps_ff    <= csr_wdata[TAP_CNT_W-1:0];
            REG_FWD_COEF_0:    fwd_coef_ff[0]  <= csr_wdata;
            REG_FWD_COEF_1:    fwd_coef_ff[1]  <= csr_wdata;
            REG_FWD_COEF_2:    fwd_coef_ff[2]  <= csr_wdata;
            REG_BACK_COEF_0:   back_coef_ff[0] <= csr_wdata;
            REG_BACK_COEF_1:   back_coef_ff[1] <= csr_wdata;
            REG_BACK_COEF_2:   back_coef_ff[2] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   `ASSERT_ALWAYS(a_clip_at_rail, !(rsp_tvalid && rsp_tuser) || rsp_tdata == OUT_HI || rsp_tdata == OUT_LO)
   `ASSERT_ALWAYS(a_stall_only_full, req_tready || (in_valid_ff && out_valid_ff))
   `ASSERT_NEXT(a_feedback_is_output, fire, past_out_ff[0] == out_filtered_ff)
   `ASSERT_NEXT(a_input_history, fire, past_in_ff[1] == $past(past_in_ff[0]))

endmodule
